### rtl/mpq_pkg.sv
// mpq_pkg: shared types and defaults for the max priority queue
// command and status codes, cell control struct, parameter defaults
// no dependencies
package mpq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TAG_BITS_DEF  = 32;
    localparam int PRIO_BITS_DEF = 8;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic enq;   // insert the new entry in priority order
        logic deq;   // every cell takes its successor's entry
    } t_cell_ctl;

endpackage

### rtl/mpq_cell.sv
// mpq_cell: one slot of the sorted chain, holds one tag and priority
// inserts the new word or shifts from a neighbor under broadcast control
// depends on mpq_pkg
module mpq_cell
    import mpq_pkg::*;
#(
    parameter int TAG_BITS  = TAG_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_occ,
    input  logic [TAG_BITS-1:0]  i_new_tag,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    input  logic                 i_prev_ins,
    input  logic [TAG_BITS-1:0]  i_prev_tag,
    input  logic [PRIO_BITS-1:0] i_prev_prio,
    input  logic [TAG_BITS-1:0]  i_next_tag,
    input  logic [PRIO_BITS-1:0] i_next_prio,
    output logic                 o_ins,
    output logic [TAG_BITS-1:0]  o_tag,
    output logic [PRIO_BITS-1:0] o_prio
);

    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  n_tag;
    logic [PRIO_BITS-1:0] n_prio;

    // new word belongs here or earlier; strict compare keeps arrival order on ties
    assign o_ins = !i_occ || (i_new_prio > r_prio);

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_ctl.enq) begin
            if (i_prev_ins) begin
                n_tag  = i_prev_tag;
                n_prio = i_prev_prio;
            end else if (o_ins) begin
                n_tag  = i_new_tag;
                n_prio = i_new_prio;
            end
        end else if (i_ctl.deq) begin
            n_tag  = i_next_tag;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

    assign o_tag  = r_tag;
    assign o_prio = r_prio;

endmodule

### rtl/max_priority_queue_top.sv
// max_priority_queue_top: bounded max priority queue built as a sorted cell chain
// instantiates mpq_cell; uses mpq_pkg
//
// The queue holds up to DEPTH (tag, priority) words in a chain of cells kept
// sorted by priority, highest first, and by arrival among equal priorities,
// so the word that a dequeue or peek returns always sits in the head cell.
// An enqueue compares the new priority against every cell at once; the first
// cell whose priority is lower (or that is empty) takes the new word and all
// cells behind it shift one place toward the tail. A dequeue shifts every
// cell one place toward the head. The result word is registered and the next
// command is accepted in the cycle after, or in the same cycle the result is
// taken, so one command per cycle is sustained while the output side keeps
// taking results. Enqueue on a full queue reports full and changes nothing;
// dequeue or peek on an empty queue reports empty with zero tag and priority;
// command code 3 does nothing and reports ok. Occupancy gives the word count
// after the operation. The fill count and the output valid flag are the only
// state that reset clears; cell contents beyond the count are never shown.
module max_priority_queue_top
    import mpq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic [TAG_BITS-1:0]  i_tag_in,
    input  logic [PRIO_BITS-1:0] i_prio_in,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [TAG_BITS-1:0]  o_tag_out,
    output logic [PRIO_BITS-1:0] o_prio_out,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_occupancy
);

    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_count;
    logic [TAG_BITS-1:0]  r_tag_out;
    logic [PRIO_BITS-1:0] r_prio_out;
    t_status              r_status;

    logic                 n_out_valid;
    logic [CNT_W-1:0]     n_count;
    logic [TAG_BITS-1:0]  n_tag_out;
    logic [PRIO_BITS-1:0] n_prio_out;
    t_status              n_status;

    logic                 accept;
    t_cell_ctl            ctl;
    logic                 is_full;
    logic                 is_empty;

    // chain wires
    logic [DEPTH-1:0]     cell_ins;
    logic [DEPTH-1:0]     cell_occ;
    logic [TAG_BITS-1:0]  cell_tag  [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];

    // output register frees up when empty or when its word is taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        ctl         = '0;
        n_count     = r_count;
        n_tag_out   = r_tag_out;
        n_prio_out  = r_prio_out;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        if (accept) begin
            n_out_valid = 1'b1;
            n_tag_out   = '0;
            n_prio_out  = '0;
            n_status    = ST_OK;
            unique case (t_cmd'(i_command))
                CMD_ENQ: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.enq = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_DEQ: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ctl.deq    = 1'b1;
                        n_count    = r_count - CNT_W'(1);
                        n_tag_out  = cell_tag[0];
                        n_prio_out = cell_prio[0];
                    end
                end
                CMD_PEEK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_tag_out  = cell_tag[0];
                        n_prio_out = cell_prio[0];
                    end
                end
                default: begin
                    // unused code: no change, ok status
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_out  <= n_tag_out;
        r_prio_out <= n_prio_out;
        r_status   <= n_status;
    end

    // the cell chain: head at index 0, tail at DEPTH-1
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 prev_ins;
        logic [TAG_BITS-1:0]  prev_tag;
        logic [PRIO_BITS-1:0] prev_prio;
        logic [TAG_BITS-1:0]  next_tag;
        logic [PRIO_BITS-1:0] next_prio;

        assign cell_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign prev_ins  = 1'b0;
            assign prev_tag  = i_tag_in;
            assign prev_prio = i_prio_in;
        end else begin : g_body
            assign prev_ins  = cell_ins[g-1];
            assign prev_tag  = cell_tag[g-1];
            assign prev_prio = cell_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // tail slot becomes free on a dequeue, its content is don't care
            assign next_tag  = cell_tag[g];
            assign next_prio = cell_prio[g];
        end else begin : g_inner
            assign next_tag  = cell_tag[g+1];
            assign next_prio = cell_prio[g+1];
        end

        mpq_cell #(
            .TAG_BITS  (TAG_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (cell_occ[g]),
            .i_new_tag   (i_tag_in),
            .i_new_prio  (i_prio_in),
            .i_prev_ins  (prev_ins),
            .i_prev_tag  (prev_tag),
            .i_prev_prio (prev_prio),
            .i_next_tag  (next_tag),
            .i_next_prio (next_prio),
            .o_ins       (cell_ins[g]),
            .o_tag       (cell_tag[g]),
            .o_prio      (cell_prio[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_tag_out   = r_tag_out;
    assign o_prio_out  = r_prio_out;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

endmodule
